FILE: hw/rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared constants, types and the product schedule of the chi-square
// distance unit.
// ----------------------------------------------------------------------------
package pcd_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int C_W         = VALUE_WIDTH + 1;      // differences and sums
   localparam int A_W         = 2 * C_W + 2;          // adjugate entries
   localparam int DET_W       = A_W + C_W + 3;        // determinant, A*d rows
   localparam int ACC_W       = DET_W + C_W + 3;      // accumulator, numerator
   localparam int CNT_W       = $clog2(C_W + 1);
   localparam int PROG_LEN    = 27;
   localparam int PC_W        = $clog2(PROG_LEN);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_COV   = 2'd1;
   localparam logic [1:0] OP_EXACT = 2'd2;

   // multiplicand sources
   localparam logic [3:0] MC_C0 = 4'd0;
   localparam logic [3:0] MC_C1 = 4'd1;
   localparam logic [3:0] MC_C2 = 4'd2;
   localparam logic [3:0] MC_C3 = 4'd3;
   localparam logic [3:0] MC_C4 = 4'd4;
   localparam logic [3:0] MC_C5 = 4'd5;
   localparam logic [3:0] MC_A0 = 4'd6;
   localparam logic [3:0] MC_A1 = 4'd7;
   localparam logic [3:0] MC_A2 = 4'd8;
   localparam logic [3:0] MC_A3 = 4'd9;
   localparam logic [3:0] MC_A4 = 4'd10;
   localparam logic [3:0] MC_A5 = 4'd11;
   localparam logic [3:0] MC_V0 = 4'd12;
   localparam logic [3:0] MC_V1 = 4'd13;
   localparam logic [3:0] MC_V2 = 4'd14;

   // serial multiplier sources
   localparam logic [3:0] MP_C0 = 4'd0;
   localparam logic [3:0] MP_C1 = 4'd1;
   localparam logic [3:0] MP_C2 = 4'd2;
   localparam logic [3:0] MP_C3 = 4'd3;
   localparam logic [3:0] MP_C4 = 4'd4;
   localparam logic [3:0] MP_C5 = 4'd5;
   localparam logic [3:0] MP_D0 = 4'd6;
   localparam logic [3:0] MP_D1 = 4'd7;
   localparam logic [3:0] MP_D2 = 4'd8;

   // destinations of a finished sum of products
   localparam logic [3:0] DST_A0   = 4'd0;
   localparam logic [3:0] DST_A1   = 4'd1;
   localparam logic [3:0] DST_A2   = 4'd2;
   localparam logic [3:0] DST_A3   = 4'd3;
   localparam logic [3:0] DST_A4   = 4'd4;
   localparam logic [3:0] DST_A5   = 4'd5;
   localparam logic [3:0] DST_DET  = 4'd6;
   localparam logic [3:0] DST_V0   = 4'd7;
   localparam logic [3:0] DST_V1   = 4'd8;
   localparam logic [3:0] DST_V2   = 4'd9;
   localparam logic [3:0] DST_NONE = 4'd10;

   typedef struct packed {
      logic [3:0] mc_sel;
      logic [3:0] mp_sel;
      logic       neg;
      logic       first;
      logic       last;
      logic [3:0] dest;
   } prog_entry_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic neg;
   } mac_ctrl_type;

   function automatic prog_entry_type mk(input logic [3:0] mc, input logic [3:0] mp,
                                         input logic ng, input logic fs, input logic ls,
                                         input logic [3:0] ds);
      prog_entry_type e;
      e.mc_sel = mc;
      e.mp_sel = mp;
      e.neg    = ng;
      e.first  = fs;
      e.last   = ls;
      e.dest   = ds;
      return e;
   endfunction

   // Adjugate entries, determinant, the rows of adj(C)*d, then d^T (adj(C) d).
   function automatic prog_entry_type prog_rom(input logic [PC_W-1:0] pc);
      prog_entry_type e;
      unique case (pc)
         5'd0:  e = mk(MC_C3, MP_C5, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd1:  e = mk(MC_C4, MP_C4, 1'b1, 1'b0, 1'b1, DST_A0);
         5'd2:  e = mk(MC_C2, MP_C4, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd3:  e = mk(MC_C1, MP_C5, 1'b1, 1'b0, 1'b1, DST_A1);
         5'd4:  e = mk(MC_C1, MP_C4, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd5:  e = mk(MC_C2, MP_C3, 1'b1, 1'b0, 1'b1, DST_A2);
         5'd6:  e = mk(MC_C0, MP_C5, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd7:  e = mk(MC_C2, MP_C2, 1'b1, 1'b0, 1'b1, DST_A3);
         5'd8:  e = mk(MC_C1, MP_C2, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd9:  e = mk(MC_C0, MP_C4, 1'b1, 1'b0, 1'b1, DST_A4);
         5'd10: e = mk(MC_C0, MP_C3, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd11: e = mk(MC_C1, MP_C1, 1'b1, 1'b0, 1'b1, DST_A5);
         5'd12: e = mk(MC_A0, MP_C0, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd13: e = mk(MC_A1, MP_C1, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd14: e = mk(MC_A2, MP_C2, 1'b0, 1'b0, 1'b1, DST_DET);
         5'd15: e = mk(MC_A0, MP_D0, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd16: e = mk(MC_A1, MP_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd17: e = mk(MC_A2, MP_D2, 1'b0, 1'b0, 1'b1, DST_V0);
         5'd18: e = mk(MC_A1, MP_D0, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd19: e = mk(MC_A3, MP_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd20: e = mk(MC_A4, MP_D2, 1'b0, 1'b0, 1'b1, DST_V1);
         5'd21: e = mk(MC_A2, MP_D0, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd22: e = mk(MC_A4, MP_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd23: e = mk(MC_A5, MP_D2, 1'b0, 1'b0, 1'b1, DST_V2);
         5'd24: e = mk(MC_V0, MP_D0, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd25: e = mk(MC_V1, MP_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd26: e = mk(MC_V2, MP_D2, 1'b0, 1'b0, 1'b1, DST_NONE);
         default: e = mk(MC_C0, MP_C0, 1'b0, 1'b1, 1'b1, DST_NONE);
      endcase
      return e;
   endfunction

endpackage

FILE: hw/rtl/pcd_mac.sv
// ----------------------------------------------------------------------------
// pcd_mac
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pcd_mac
   import pcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mac_ctrl_type       ctrl,
   input  logic [ACC_W-1:0]   mcand,
   input  logic [C_W-1:0]     mplier,
   output logic [ACC_W-1:0]   acc,
   output logic               done
);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] mcand_ff;
   logic [C_W-1:0]   mplier_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             neg_ff;
   logic             done_ff;
   logic [ACC_W-1:0] term;
   logic             sub;

   // The top multiplier bit carries negative weight, hence the flip of sign.
   always_comb begin
      term   = mplier_ff[0] ? mcand_ff : '0;
      sub    = neg_ff ^ (cnt_ff == CNT_W'(C_W - 1));
      acc_in = sub ? (acc_ff - term) : (acc_ff + term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         acc_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.load) begin
            mcand_ff  <= mcand;
            mplier_ff <= mplier;
            neg_ff    <= ctrl.neg;
            cnt_ff    <= '0;
            run_ff    <= 1'b1;
            if (ctrl.clear) begin
               acc_ff <= '0;
            end
         end else if (run_ff) begin
            acc_ff    <= acc_in;
            mcand_ff  <= {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[C_W-1:1]};
            cnt_ff    <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(C_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

`ifndef ASSERT_OFF
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> !run_ff)
      else $error("pcd_mac: load while a product is running");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("pcd_mac: done without a running product");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff <= CNT_W'(C_W - 1))
      else $error("pcd_mac: bit counter out of range");
`endif

endmodule

FILE: hw/rtl/point_chi2_distance_3d_unit.sv
// A load request is stored directly from the idle state; a compare request runs
// 27 products in the serial multiply-accumulate unit, then a positive-definiteness
// check, a restoring division by the determinant and the output state.
// Throughput: one request at a time; the next is taken as soon as the
// result is in the output register. Synchronous reset clears the reference.
// ----------------------------------------------------------------------------
// point_chi2_distance_3d_unit
// Chi-square distance of a 3D point to a stored reference under a 3x3
// covariance, computed as d^T adj(C) d / det(C) with bit-serial arithmetic.
// ----------------------------------------------------------------------------
module point_chi2_distance_3d_unit
   import pcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz
   input  logic [287:0] req_tdata,
   // op
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // chi2_value
   output logic [31:0]  rsp_tdata,
   // fit_ok
   output logic [0:0]   rsp_tuser
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MLOAD = 3'd1;
   localparam logic [2:0] ST_MWAIT = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]             state_ff;
   logic [VALUE_WIDTH-1:0] ref_pos_ff [3];
   logic [VALUE_WIDTH-1:0] ref_cov_ff [6];
   logic [C_W-1:0]         c_ff [6];
   logic [C_W-1:0]         d_ff [3];
   logic [A_W-1:0]         a_ff [6];
   logic [DET_W-1:0]       det_ff;
   logic [DET_W-1:0]       v_ff [3];
   logic [PC_W-1:0]        pc_ff;
   logic [ACC_W-1:0]       rem_ff, dsh_ff;
   logic [ACC_W-1:0]       diff;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic                   sat_ff, fit_ff;
   logic [CNT_W-1:0]       dcnt_ff;
   logic                   rsp_tvalid_ff;
   logic [31:0]            rsp_tdata_ff;
   logic                   rsp_fit_ff;

   prog_entry_type         entry;
   mac_ctrl_type           mac_ctrl;
   logic [ACC_W-1:0]       mcand;
   logic [C_W-1:0]         mplier;
   logic [ACC_W-1:0]       acc;
   logic                   mac_done;
   logic                   accept;
   logic                   pd_ok;
   logic [1:0]             op;

   assign op         = req_tuser;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign entry      = prog_rom(pc_ff);

   always_comb begin
      unique case (entry.mc_sel)
         MC_C0: mcand = {{(ACC_W-C_W){c_ff[0][C_W-1]}}, c_ff[0]};
         MC_C1: mcand = {{(ACC_W-C_W){c_ff[1][C_W-1]}}, c_ff[1]};
         MC_C2: mcand = {{(ACC_W-C_W){c_ff[2][C_W-1]}}, c_ff[2]};
         MC_C3: mcand = {{(ACC_W-C_W){c_ff[3][C_W-1]}}, c_ff[3]};
         MC_C4: mcand = {{(ACC_W-C_W){c_ff[4][C_W-1]}}, c_ff[4]};
         MC_C5: mcand = {{(ACC_W-C_W){c_ff[5][C_W-1]}}, c_ff[5]};
         MC_A0: mcand = {{(ACC_W-A_W){a_ff[0][A_W-1]}}, a_ff[0]};
         MC_A1: mcand = {{(ACC_W-A_W){a_ff[1][A_W-1]}}, a_ff[1]};
         MC_A2: mcand = {{(ACC_W-A_W){a_ff[2][A_W-1]}}, a_ff[2]};
         MC_A3: mcand = {{(ACC_W-A_W){a_ff[3][A_W-1]}}, a_ff[3]};
         MC_A4: mcand = {{(ACC_W-A_W){a_ff[4][A_W-1]}}, a_ff[4]};
         MC_A5: mcand = {{(ACC_W-A_W){a_ff[5][A_W-1]}}, a_ff[5]};
         MC_V0: mcand = {{(ACC_W-DET_W){v_ff[0][DET_W-1]}}, v_ff[0]};
         MC_V1: mcand = {{(ACC_W-DET_W){v_ff[1][DET_W-1]}}, v_ff[1]};
         MC_V2: mcand = {{(ACC_W-DET_W){v_ff[2][DET_W-1]}}, v_ff[2]};
         default: mcand = '0;
      endcase
      unique case (entry.mp_sel)
         MP_C0: mplier = c_ff[0];
         MP_C1: mplier = c_ff[1];
         MP_C2: mplier = c_ff[2];
         MP_C3: mplier = c_ff[3];
         MP_C4: mplier = c_ff[4];
         MP_C5: mplier = c_ff[5];
         MP_D0: mplier = d_ff[0];
         MP_D1: mplier = d_ff[1];
         MP_D2: mplier = d_ff[2];
         default: mplier = '0;
      endcase
      mac_ctrl.load  = (state_ff == ST_MLOAD);
      mac_ctrl.clear = entry.first;
      mac_ctrl.neg   = entry.neg;
   end

   pcd_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .mcand  (mcand),
      .mplier (mplier),
      .acc    (acc),
      .done   (mac_done)
   );

   // Leading minors: c_xx, the upper 2x2 minor (a22 entry) and det must be > 0.
   assign pd_ok = !c_ff[0][C_W-1] && (|c_ff[0])
                  && !a_ff[5][A_W-1] && (|a_ff[5])
                  && !det_ff[DET_W-1] && (|det_ff);

   assign diff   = rem_ff - dsh_ff;
   assign quo_in = {quo_ff[VALUE_WIDTH-2:0], !diff[ACC_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pc_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) ref_pos_ff[i] <= '0;
         for (int i = 0; i < 6; i++) ref_cov_ff[i] <= '0;
      end else begin
         // The output state refills the register itself when it is taken.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (op == OP_LOAD) begin
                     for (int i = 0; i < 3; i++) begin
                        ref_pos_ff[i] <= req_tdata[i*VALUE_WIDTH +: VALUE_WIDTH];
                     end
                     for (int i = 0; i < 6; i++) begin
                        ref_cov_ff[i] <= req_tdata[(i+3)*VALUE_WIDTH +: VALUE_WIDTH];
                     end
                  end else if (op == OP_COV || op == OP_EXACT) begin
                     for (int i = 0; i < 3; i++) begin
                        d_ff[i] <= {ref_pos_ff[i][VALUE_WIDTH-1], ref_pos_ff[i]}
                           - {req_tdata[i*VALUE_WIDTH + VALUE_WIDTH - 1],
                              req_tdata[i*VALUE_WIDTH +: VALUE_WIDTH]};
                     end
                     for (int i = 0; i < 6; i++) begin
                        c_ff[i] <= {ref_cov_ff[i][VALUE_WIDTH-1], ref_cov_ff[i]}
                           + ((op == OP_COV)
                              ? {req_tdata[(i+3)*VALUE_WIDTH + VALUE_WIDTH - 1],
                                 req_tdata[(i+3)*VALUE_WIDTH +: VALUE_WIDTH]}
                              : {C_W{1'b0}});
                     end
                     pc_ff    <= '0;
                     state_ff <= ST_MLOAD;
                  end
               end
            end
            ST_MLOAD: begin
               state_ff <= ST_MWAIT;
            end
            ST_MWAIT: begin
               if (mac_done) begin
                  if (entry.last) begin
                     unique case (entry.dest)
                        DST_A0:  a_ff[0] <= acc[A_W-1:0];
                        DST_A1:  a_ff[1] <= acc[A_W-1:0];
                        DST_A2:  a_ff[2] <= acc[A_W-1:0];
                        DST_A3:  a_ff[3] <= acc[A_W-1:0];
                        DST_A4:  a_ff[4] <= acc[A_W-1:0];
                        DST_A5:  a_ff[5] <= acc[A_W-1:0];
                        DST_DET: det_ff  <= acc[DET_W-1:0];
                        DST_V0:  v_ff[0] <= acc[DET_W-1:0];
                        DST_V1:  v_ff[1] <= acc[DET_W-1:0];
                        DST_V2:  v_ff[2] <= acc[DET_W-1:0];
                        default: ;
                     endcase
                  end
                  if (pc_ff == PC_W'(PROG_LEN - 1)) begin
                     state_ff <= ST_CHECK;
                  end else begin
                     pc_ff    <= pc_ff + 1'b1;
                     state_ff <= ST_MLOAD;
                  end
               end
            end
            ST_CHECK: begin
               if (pd_ok) begin
                  rem_ff   <= acc;
                  dsh_ff   <= {{(ACC_W-DET_W-VALUE_WIDTH){1'b0}}, det_ff,
                               {VALUE_WIDTH{1'b0}}};
                  dcnt_ff  <= '0;
                  quo_ff   <= '0;
                  sat_ff   <= 1'b0;
                  fit_ff   <= 1'b1;
                  state_ff <= ST_DIV;
               end else begin
                  quo_ff   <= '0;
                  sat_ff   <= 1'b0;
                  fit_ff   <= 1'b0;
                  state_ff <= ST_OUT;
               end
            end
            ST_DIV: begin
               // The first step only tests the numerator against det * 2^32.
               dsh_ff  <= {1'b0, dsh_ff[ACC_W-1:1]};
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == '0) begin
                  sat_ff <= !diff[ACC_W-1];
               end else begin
                  quo_ff <= quo_in;
                  if (!diff[ACC_W-1]) begin
                     rem_ff <= diff;
                  end
               end
               if (dcnt_ff == CNT_W'(VALUE_WIDTH)) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= sat_ff ? {VALUE_WIDTH{1'b1}} : quo_ff;
                  rsp_fit_ff    <= fit_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_fit_ff;

`ifndef ASSERT_OFF
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_MWAIT)
      else $error("product finished outside the multiply phase");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tdata == '0)
      else $error("failed fit with a non-zero distance");
   a_div_det_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> (!det_ff[DET_W-1] && (|det_ff)))
      else $error("division with a non-positive determinant");
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_W'(PROG_LEN - 1))
      else $error("product counter out of range");
`endif

endmodule
